// ----- rtl/pbca_pkg.sv -----
// shared types, constants and status codes for the polygon box clip area block
// no dependencies; used by every module of the block except pbca_ram
`timescale 1ns / 1ps

package pbca_pkg;

   // fixed point format of coordinates and window registers
   localparam int FRAC_BITS = 15;

   // defaults handed to the top level parameters
   localparam int MAX_VERTICES_DEF = 64;
   localparam int CLIP_DEPTH_DEF   = 256;

   localparam int COORD_W  = 16;
   localparam int VERTEX_W = 2 * COORD_W;
   localparam int AREA_W   = 31;
   localparam int STATUS_W = 3;
   localparam int RSP_W    = 40;
   localparam int ACC_W    = 48;
   localparam int NUM_W    = 33;
   localparam int DEN_W    = 17;
   localparam int CSR_IDX_W = 2;

   localparam logic [COORD_W-1:0] WIN_MAX_RESET = 16'd32768;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_WINDOW  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_POLYGON = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LEFT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TOP    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BOTTOM = 2'd3;

   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] bottom;
   } window_type;

   // commands from the sequencer to the datapath
   typedef struct packed {
      logic take;
      logic mul;
      logic mul_first;
      logic acc_add;
      logic acc_clear;
      logic prev_from_cur;
      logic ld_prev;
      logic ld_cur;
      logic ld_first;
      logic idx_inc;
      logic rd_last;
      logic pass_init;
      logic pass_next;
      logic cut_setup;
      logic div_start;
      logic wr_cut;
      logic wr_cur;
      logic chk;
      logic fail_ovf;
      logic fail_empty;
      logic fin;
      logic emit;
   } cmd_type;

   // status from the datapath to the sequencer
   typedef struct packed {
      logic last;
      logic stored;
      logic was_first;
      logic chk_bad;
      logic ci;
      logic pi;
      logic div_busy;
      logic k_full;
      logic k_zero;
      logic idx_end;
      logic side_last;
   } sts_type;

endpackage

// ----- rtl/pbca_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pbca_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/pbca_div.sv -----
// restoring divider on magnitudes, one quotient bit per cycle
// depends on pbca_pkg
`timescale 1ns / 1ps

module pbca_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pbca_pkg::NUM_W-1:0] num_mag,
   input  logic [pbca_pkg::DEN_W-1:0] den_mag,
   output logic                       busy,
   output logic [pbca_pkg::NUM_W-1:0] quot
);

   localparam int NW = pbca_pkg::NUM_W;
   localparam int DW = pbca_pkg::DEN_W;
   localparam int CNT_W = $clog2(NW + 1);

   logic [NW-1:0]    shift_ff, shift_in;
   logic [DW-1:0]    den_ff, den_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [NW-1:0]    quot_ff, quot_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic [DW:0]      trial;
   logic             ge;

   assign trial = {rem_ff, shift_ff[NW-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      shift_in = shift_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      if (start) begin
         shift_in = num_mag;
         den_in   = den_mag;
         rem_in   = '0;
         quot_in  = '0;
         count_in = CNT_W'(NW);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = ge ? DW'(trial - {1'b0, den_ff}) : trial[DW-1:0];
         quot_in  = {quot_ff[NW-2:0], ge};
         shift_in = {shift_ff[NW-2:0], 1'b0};
         count_in = count_ff - 1'b1;
         busy_in  = count_ff != CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      shift_ff <= shift_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

// ----- rtl/pbca_datapath.sv -----
// datapath: vertex stores, area accumulator, clip intersection and checks
// depends on pbca_pkg, pbca_ram, pbca_div
`timescale 1ns / 1ps

module pbca_datapath #(
   parameter int MAX_VERTICES = pbca_pkg::MAX_VERTICES_DEF,
   parameter int CLIP_DEPTH   = pbca_pkg::CLIP_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pbca_pkg::cmd_type             cmd,
   output pbca_pkg::sts_type             sts,
   input  pbca_pkg::window_type          win,
   input  logic [pbca_pkg::VERTEX_W-1:0] req_vertex,
   input  logic                          req_last,
   output logic [pbca_pkg::AREA_W-1:0]   res_area,
   output logic [pbca_pkg::STATUS_W-1:0] res_status
);

   localparam int CW  = pbca_pkg::COORD_W;
   localparam int VW  = pbca_pkg::VERTEX_W;
   localparam int AW  = $clog2(CLIP_DEPTH);
   localparam int NW  = $clog2(CLIP_DEPTH + 1);
   localparam int ACW = pbca_pkg::ACC_W;
   localparam int LOAD_CAP = (MAX_VERTICES < CLIP_DEPTH) ? MAX_VERTICES : CLIP_DEPTH;
   localparam logic [NW-1:0] CAP_C   = NW'(LOAD_CAP);
   localparam logic [NW-1:0] DEPTH_C = NW'(CLIP_DEPTH);
   localparam logic [NW-1:0] THREE_C = NW'(3);
   localparam logic [CW:0]   ONE_C   = (CW + 1)'(1 << pbca_pkg::FRAC_BITS);
   // input area below the limit: doubled area * 10000 < 2^(2f+1)
   localparam longint AREA_T = longint'(1) << (2 * pbca_pkg::FRAC_BITS + 1);
   localparam longint MIN_TW = (AREA_T + 64'd9999) / 64'd10000;
   localparam int SHR = (2 * pbca_pkg::FRAC_BITS >= 30) ? 2 * pbca_pkg::FRAC_BITS - 30 : 0;
   localparam int SHL = (2 * pbca_pkg::FRAC_BITS < 30) ? 30 - 2 * pbca_pkg::FRAC_BITS : 0;
   localparam logic [ACW-1:0] AREA_MAX_C = {{(ACW - pbca_pkg::AREA_W){1'b0}},
                                            {pbca_pkg::AREA_W{1'b1}}};

   logic [NW-1:0]  cnt_ff, cnt_in, k_ff, k_in, idx_ff, idx_in;
   logic [1:0]     side_ff, side_in;
   logic [VW-1:0]  prev_ff, prev_in, cur_ff, cur_in, first_ff, first_in;
   logic [VW-1:0]  pa_ff, pa_in, pb_ff, pb_in;
   logic signed [ACW-1:0] acc_ff, acc_in;
   logic           ovf_ff, ovf_in, badc_ff, badc_in, stored_ff, stored_in;
   logic           was_first_ff, was_first_in, last_ff, last_in;
   logic           ci_ff, ci_in, pi_ff, pi_in;
   logic signed [33:0] num_ff, num_in;
   logic signed [16:0] den_ff, den_in;
   logic [CW-1:0]  base_ff, base_in, bound_ff, bound_in;
   logic [pbca_pkg::AREA_W-1:0]   area_ff, area_in;
   logic [pbca_pkg::STATUS_W-1:0] status_ff, status_in;

   logic          a_we, b_we, pass_wr;
   logic [AW-1:0] a_waddr, rd_addr;
   logic [VW-1:0] a_wdata, pass_wdata, a_rdata, b_rdata, src_rdata;
   logic [VW-1:0] mul_q, cut_c;
   logic signed [32:0] cross_c;
   logic [pbca_pkg::NUM_W-1:0] num_mag, quot;
   logic [pbca_pkg::DEN_W-1:0] den_mag;
   logic          div_busy, q_neg, den_zero;
   logic [CW-1:0] q_low, q_s, other_c, bound_c;
   logic signed [16:0] diff_c, d_c, dn_c;
   logic [CW-1:0] base_c;
   logic [ACW-1:0] acc_mag, tw, tw_s;
   logic          bad_win;
   logic [pbca_pkg::STATUS_W-1:0] chk_code;

   function automatic logic inside_win(input logic [VW-1:0] v, input logic [1:0] s,
                                       input pbca_pkg::window_type w);
      logic r;
      case (s)
         2'd0: r = v[CW-1:0] >= w.left;
         2'd1: r = v[CW-1:0] <= w.right;
         2'd2: r = v[VW-1:CW] >= w.top;
         default: r = v[VW-1:CW] <= w.bottom;
      endcase
      return r;
   endfunction

   // ping-pong stores: even sides read a and write b, odd sides the other way
   assign src_rdata  = side_ff[0] ? b_rdata : a_rdata;
   assign rd_addr    = cmd.rd_last ? AW'(cnt_ff - 1'b1) : idx_ff[AW-1:0];
   assign pass_wr    = cmd.wr_cut | cmd.wr_cur;
   assign pass_wdata = cmd.wr_cut ? cut_c : cur_ff;
   assign a_we       = (cmd.take & (cnt_ff < CAP_C)) | (pass_wr & side_ff[0]);
   assign b_we       = pass_wr & ~side_ff[0];
   assign a_waddr    = cmd.take ? cnt_ff[AW-1:0] : k_ff[AW-1:0];
   assign a_wdata    = cmd.take ? req_vertex : pass_wdata;

   pbca_ram #(.WIDTH(VW), .DEPTH(CLIP_DEPTH)) u_store_a (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_addr (rd_addr),
      .rd_data (a_rdata)
   );

   pbca_ram #(.WIDTH(VW), .DEPTH(CLIP_DEPTH)) u_store_b (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (k_ff[AW-1:0]),
      .wr_data (pass_wdata),
      .rd_addr (rd_addr),
      .rd_data (b_rdata)
   );

   // cross product terms
   assign mul_q   = cmd.mul_first ? first_ff : cur_ff;
   assign cross_c = $signed({1'b0, pa_ff}) - $signed({1'b0, pb_ff});

   // intersection set-up
   always_comb begin
      case (side_ff)
         2'd0: bound_c = win.left;
         2'd1: bound_c = win.right;
         2'd2: bound_c = win.top;
         default: bound_c = win.bottom;
      endcase
      if (!side_ff[1]) begin
         diff_c = $signed({1'b0, bound_c}) - $signed({1'b0, prev_ff[CW-1:0]});
         d_c    = $signed({1'b0, cur_ff[VW-1:CW]}) - $signed({1'b0, prev_ff[VW-1:CW]});
         dn_c   = $signed({1'b0, cur_ff[CW-1:0]}) - $signed({1'b0, prev_ff[CW-1:0]});
         base_c = prev_ff[VW-1:CW];
      end else begin
         diff_c = $signed({1'b0, bound_c}) - $signed({1'b0, prev_ff[VW-1:CW]});
         d_c    = $signed({1'b0, cur_ff[CW-1:0]}) - $signed({1'b0, prev_ff[CW-1:0]});
         dn_c   = $signed({1'b0, cur_ff[VW-1:CW]}) - $signed({1'b0, prev_ff[VW-1:CW]});
         base_c = prev_ff[CW-1:0];
      end
   end

   assign num_mag  = num_ff[33] ? pbca_pkg::NUM_W'(-num_ff) : pbca_pkg::NUM_W'(num_ff);
   assign den_mag  = den_ff[16] ? pbca_pkg::DEN_W'(-den_ff) : pbca_pkg::DEN_W'(den_ff);
   assign q_neg    = num_ff[33] ^ den_ff[16];
   assign den_zero = den_ff == '0;

   pbca_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .num_mag (num_mag),
      .den_mag (den_mag),
      .busy    (div_busy),
      .quot    (quot)
   );

   // truncating division, only the low coordinate bits survive packing
   assign q_low   = quot[CW-1:0];
   assign q_s     = den_zero ? '0 : (q_neg ? CW'(-q_low) : q_low);
   assign other_c = base_ff + q_s;
   assign cut_c   = side_ff[1] ? {bound_ff, other_c} : {other_c, bound_ff};

   // checks before clipping, in priority order
   assign acc_mag = acc_ff[ACW-1] ? ACW'(-acc_ff) : ACW'(acc_ff);
   assign bad_win = (win.left >= win.right) || (win.top >= win.bottom) ||
                    ({1'b0, win.right} > ONE_C) || ({1'b0, win.bottom} > ONE_C);

   always_comb begin
      if (bad_win) begin
         chk_code = pbca_pkg::ST_BAD_WINDOW;
      end else if (ovf_ff) begin
         chk_code = pbca_pkg::ST_OVERFLOW;
      end else if (cnt_ff < THREE_C || badc_ff || acc_mag < ACW'(MIN_TW)) begin
         chk_code = pbca_pkg::ST_BAD_POLYGON;
      end else begin
         chk_code = pbca_pkg::ST_OK;
      end
   end

   // area rescale to 2^-30 units with saturation
   always_comb begin
      tw = acc_mag >> (1 + SHR);
      if (tw > (AREA_MAX_C >> SHL)) begin
         tw_s = AREA_MAX_C;
      end else begin
         tw_s = tw << SHL;
      end
      if (tw_s > AREA_MAX_C) begin
         tw_s = AREA_MAX_C;
      end
   end

   always_comb begin
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      side_in      = side_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      first_in     = first_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      badc_in      = badc_ff;
      stored_in    = stored_ff;
      was_first_in = was_first_ff;
      last_in      = last_ff;
      ci_in        = ci_ff;
      pi_in        = pi_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      base_in      = base_ff;
      bound_in     = bound_ff;
      area_in      = area_ff;
      status_in    = status_ff;

      if (cmd.take) begin
         was_first_in = cnt_ff == '0;
         last_in      = req_last;
         if (cnt_ff < CAP_C) begin
            stored_in = 1'b1;
            cur_in    = req_vertex;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == '0) begin
               first_in = req_vertex;
            end
            if ({1'b0, req_vertex[CW-1:0]} > ONE_C || {1'b0, req_vertex[VW-1:CW]} > ONE_C) begin
               badc_in = 1'b1;
            end
         end else begin
            stored_in = 1'b0;
            ovf_in    = 1'b1;
         end
      end
      if (cmd.mul) begin
         pa_in = prev_ff[CW-1:0] * mul_q[VW-1:CW];
         pb_in = mul_q[CW-1:0] * prev_ff[VW-1:CW];
      end
      if (cmd.acc_clear) begin
         acc_in = '0;
      end
      if (cmd.acc_add) begin
         acc_in = acc_ff + ACW'(cross_c);
      end
      if (cmd.prev_from_cur) begin
         prev_in = cur_ff;
      end
      if (cmd.ld_prev) begin
         prev_in = src_rdata;
      end
      if (cmd.ld_cur) begin
         cur_in = src_rdata;
         ci_in  = inside_win(src_rdata, side_ff, win);
         pi_in  = inside_win(prev_ff, side_ff, win);
      end
      if (cmd.ld_first) begin
         first_in = src_rdata;
         prev_in  = src_rdata;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.pass_init) begin
         side_in = 2'd0;
         idx_in  = '0;
         k_in    = '0;
      end
      if (cmd.pass_next) begin
         cnt_in  = k_ff;
         k_in    = '0;
         idx_in  = '0;
         side_in = side_ff + 1'b1;
      end
      if (cmd.cut_setup) begin
         num_in   = 34'(diff_c) * 34'(d_c);
         den_in   = dn_c;
         base_in  = base_c;
         bound_in = bound_c;
      end
      if (pass_wr) begin
         k_in = k_ff + 1'b1;
      end
      if (cmd.chk) begin
         status_in = chk_code;
         area_in   = '0;
      end
      if (cmd.fail_ovf) begin
         status_in = pbca_pkg::ST_OVERFLOW;
         area_in   = '0;
      end
      if (cmd.fail_empty) begin
         status_in = pbca_pkg::ST_EMPTY;
         area_in   = '0;
      end
      if (cmd.fin) begin
         status_in = pbca_pkg::ST_OK;
         area_in   = tw_s[pbca_pkg::AREA_W-1:0];
      end
      if (cmd.emit) begin
         cnt_in   = '0;
         acc_in   = '0;
         ovf_in   = 1'b0;
         badc_in  = 1'b0;
         last_in  = 1'b0;
         first_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         k_ff         <= '0;
         idx_ff       <= '0;
         side_ff      <= 2'd0;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         badc_ff      <= 1'b0;
         stored_ff    <= 1'b0;
         was_first_ff <= 1'b0;
         last_ff      <= 1'b0;
         first_ff     <= '0;
      end else begin
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         idx_ff       <= idx_in;
         side_ff      <= side_in;
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
         badc_ff      <= badc_in;
         stored_ff    <= stored_in;
         was_first_ff <= was_first_in;
         last_ff      <= last_in;
         first_ff     <= first_in;
      end
      prev_ff   <= prev_in;
      cur_ff    <= cur_in;
      pa_ff     <= pa_in;
      pb_ff     <= pb_in;
      ci_ff     <= ci_in;
      pi_ff     <= pi_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      base_ff   <= base_in;
      bound_ff  <= bound_in;
      area_ff   <= area_in;
      status_ff <= status_in;
   end

   always_comb begin
      sts.last      = last_ff;
      sts.stored    = stored_ff;
      sts.was_first = was_first_ff;
      sts.chk_bad   = chk_code != pbca_pkg::ST_OK;
      sts.ci        = ci_ff;
      sts.pi        = pi_ff;
      sts.div_busy  = div_busy;
      sts.k_full    = k_ff >= DEPTH_C;
      sts.k_zero    = k_ff == '0;
      sts.idx_end   = idx_ff == cnt_ff;
      sts.side_last = side_ff == 2'd3;
   end

   assign res_area   = area_ff;
   assign res_status = status_ff;

endmodule

// ----- rtl/pbca_ctrl.sv -----
// sequencer: vertex load, four clip passes, area pass and result hand-off
// depends on pbca_pkg
`timescale 1ns / 1ps

module pbca_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              out_free,
   input  pbca_pkg::sts_type sts,
   output pbca_pkg::cmd_type cmd
);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_LD_MUL = 5'd1;
   localparam logic [4:0] S_LD_ACC = 5'd2;
   localparam logic [4:0] S_CL_MUL = 5'd3;
   localparam logic [4:0] S_CL_ACC = 5'd4;
   localparam logic [4:0] S_CHECK  = 5'd5;
   localparam logic [4:0] S_P_RDP  = 5'd6;
   localparam logic [4:0] S_P_LDP  = 5'd7;
   localparam logic [4:0] S_P_RDC  = 5'd8;
   localparam logic [4:0] S_P_LDC  = 5'd9;
   localparam logic [4:0] S_P_DEC  = 5'd10;
   localparam logic [4:0] S_P_MUL  = 5'd11;
   localparam logic [4:0] S_P_DIVS = 5'd12;
   localparam logic [4:0] S_P_DIVW = 5'd13;
   localparam logic [4:0] S_P_WRX  = 5'd14;
   localparam logic [4:0] S_P_WRC  = 5'd15;
   localparam logic [4:0] S_P_NXT  = 5'd16;
   localparam logic [4:0] S_P_CHK  = 5'd17;
   localparam logic [4:0] S_P_END  = 5'd18;
   localparam logic [4:0] S_A_RD0  = 5'd19;
   localparam logic [4:0] S_A_LD0  = 5'd20;
   localparam logic [4:0] S_A_CHK  = 5'd21;
   localparam logic [4:0] S_A_RDC  = 5'd22;
   localparam logic [4:0] S_A_LDC  = 5'd23;
   localparam logic [4:0] S_A_MUL  = 5'd24;
   localparam logic [4:0] S_A_ACC  = 5'd25;
   localparam logic [4:0] S_A_CMUL = 5'd26;
   localparam logic [4:0] S_A_CACC = 5'd27;
   localparam logic [4:0] S_A_FIN  = 5'd28;
   localparam logic [4:0] S_DONE   = 5'd29;

   logic [4:0] state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_LD_MUL;
            end
         end
         S_LD_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_LD_ACC;
         end
         S_LD_ACC: begin
            cmd.acc_add       = sts.stored & ~sts.was_first;
            cmd.prev_from_cur = sts.stored;
            state_in          = sts.last ? S_CL_MUL : S_IDLE;
         end
         S_CL_MUL: begin
            cmd.mul       = 1'b1;
            cmd.mul_first = 1'b1;
            state_in      = S_CL_ACC;
         end
         S_CL_ACC: begin
            cmd.acc_add = 1'b1;
            state_in    = S_CHECK;
         end
         S_CHECK: begin
            cmd.chk = 1'b1;
            if (sts.chk_bad) begin
               state_in = S_DONE;
            end else begin
               cmd.pass_init = 1'b1;
               state_in      = S_P_RDP;
            end
         end
         S_P_RDP: begin
            cmd.rd_last = 1'b1;
            state_in    = S_P_LDP;
         end
         S_P_LDP: begin
            cmd.ld_prev = 1'b1;
            state_in    = S_P_RDC;
         end
         S_P_RDC: begin
            state_in = S_P_LDC;
         end
         S_P_LDC: begin
            cmd.ld_cur = 1'b1;
            state_in   = S_P_DEC;
         end
         S_P_DEC: begin
            if (sts.ci != sts.pi) begin
               state_in = S_P_MUL;
            end else if (sts.ci) begin
               state_in = S_P_WRC;
            end else begin
               state_in = S_P_NXT;
            end
         end
         S_P_MUL: begin
            cmd.cut_setup = 1'b1;
            state_in      = S_P_DIVS;
         end
         S_P_DIVS: begin
            cmd.div_start = 1'b1;
            state_in      = S_P_DIVW;
         end
         S_P_DIVW: begin
            if (!sts.div_busy) begin
               state_in = S_P_WRX;
            end
         end
         S_P_WRX: begin
            if (sts.k_full) begin
               cmd.fail_ovf = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.wr_cut = 1'b1;
               state_in   = sts.ci ? S_P_WRC : S_P_NXT;
            end
         end
         S_P_WRC: begin
            if (sts.k_full) begin
               cmd.fail_ovf = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.wr_cur = 1'b1;
               state_in   = S_P_NXT;
            end
         end
         S_P_NXT: begin
            cmd.prev_from_cur = 1'b1;
            cmd.idx_inc       = 1'b1;
            state_in          = S_P_CHK;
         end
         S_P_CHK: begin
            state_in = sts.idx_end ? S_P_END : S_P_RDC;
         end
         S_P_END: begin
            if (sts.k_zero) begin
               cmd.fail_empty = 1'b1;
               state_in       = S_DONE;
            end else begin
               cmd.pass_next = 1'b1;
               state_in      = sts.side_last ? S_A_RD0 : S_P_RDP;
            end
         end
         S_A_RD0: begin
            cmd.acc_clear = 1'b1;
            state_in      = S_A_LD0;
         end
         S_A_LD0: begin
            cmd.ld_first = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = S_A_CHK;
         end
         S_A_CHK: begin
            state_in = sts.idx_end ? S_A_CMUL : S_A_RDC;
         end
         S_A_RDC: begin
            state_in = S_A_LDC;
         end
         S_A_LDC: begin
            cmd.ld_cur = 1'b1;
            state_in   = S_A_MUL;
         end
         S_A_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_A_ACC;
         end
         S_A_ACC: begin
            cmd.acc_add       = 1'b1;
            cmd.prev_from_cur = 1'b1;
            cmd.idx_inc       = 1'b1;
            state_in          = S_A_CHK;
         end
         S_A_CMUL: begin
            cmd.mul       = 1'b1;
            cmd.mul_first = 1'b1;
            state_in      = S_A_CACC;
         end
         S_A_CACC: begin
            cmd.acc_add = 1'b1;
            state_in    = S_A_FIN;
         end
         S_A_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/polygon_box_clip_area_top.sv -----
// top level of the polygon box clip area block: window registers, result register
// depends on pbca_pkg, pbca_ctrl, pbca_datapath (and below it pbca_ram, pbca_div)
`timescale 1ns / 1ps

// channel   direction  fields (lowest bit first)
// req_      in         tdata: vertex_x[15:0], vertex_y[31:16]; tlast: last_vertex
// rsp_      out        tdata: clipped_area[30:0], status[33:31], zero pad to 40 bits
// csr_      in         index: register 0 left, 1 top, 2 right, 3 bottom; wdata 16 bits
//
// a vertex without tlast is stored, multiplied and accumulated, in that order
// the closing vertex adds: the checks, four clip passes over the vertices with a serial
// divide per edge crossing, then the area pass over the clipped vertices, and the
// hand-off of the word to the output register
// the result waits in an output register; new vertices are taken meanwhile, and the
// next result leaves the sequencer only once that register is free
// reset clears the window to its full range and empties the vertex count; the stores
// need no clearing since only written entries are read

module polygon_box_clip_area_top #(
   parameter int MAX_VERTICES = pbca_pkg::MAX_VERTICES_DEF,
   parameter int CLIP_DEPTH   = pbca_pkg::CLIP_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // vertex words
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [pbca_pkg::VERTEX_W-1:0]  req_tdata,  // vertex_x, vertex_y
   input  logic                           req_tlast,  // last_vertex
   // result words
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [pbca_pkg::RSP_W-1:0]     rsp_tdata,  // clipped_area, status, pad
   // window register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pbca_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pbca_pkg::COORD_W-1:0]   csr_wdata
);

   pbca_pkg::cmd_type    cmd;
   pbca_pkg::sts_type    sts;
   pbca_pkg::window_type win_ff, win_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pbca_pkg::RSP_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [pbca_pkg::AREA_W-1:0]   res_area;
   logic [pbca_pkg::STATUS_W-1:0] res_status;
   logic                          out_free;

   // window registers, always writable
   assign csr_ready = 1'b1;

   always_comb begin
      win_in = win_ff;
      if (csr_valid) begin
         case (csr_index)
            pbca_pkg::REG_LEFT:   win_in.left   = csr_wdata;
            pbca_pkg::REG_TOP:    win_in.top    = csr_wdata;
            pbca_pkg::REG_RIGHT:  win_in.right  = csr_wdata;
            pbca_pkg::REG_BOTTOM: win_in.bottom = csr_wdata;
            default: win_in = win_ff;
         endcase
      end
   end

   // output register is free when empty or being drained this cycle
   assign out_free = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(pbca_pkg::RSP_W - pbca_pkg::AREA_W - pbca_pkg::STATUS_W){1'b0}},
                         res_status, res_area};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.left   <= '0;
         win_ff.top    <= '0;
         win_ff.right  <= pbca_pkg::WIN_MAX_RESET;
         win_ff.bottom <= pbca_pkg::WIN_MAX_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         win_ff       <= win_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   pbca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .out_free  (out_free),
      .sts       (sts),
      .cmd       (cmd)
   );

   pbca_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .CLIP_DEPTH   (CLIP_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .win        (win_ff),
      .req_vertex (req_tdata),
      .req_last   (req_tlast),
      .res_area   (res_area),
      .res_status (res_status)
   );

endmodule
